>>> rtl/bbpe_pkg.sv
// Shared types and constants for the bicubic Bezier patch evaluator.
package bbpe_pkg;
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TW = FRAC_BITS + 1;

  localparam logic [1:0] CFG_DIV_U = 2'd0;
  localparam logic [1:0] CFG_DIV_V = 2'd1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  point_index;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [7:0]  grid_col;
    logic [7:0]  grid_row;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [15:0] vertex_index;
    logic        range_error;
  } out_item_t;

  // Job handed from the front end to the evaluation engine.
  typedef struct packed {
    logic [TW-1:0] tu;
    logic [TW-1:0] tv;
    logic [15:0]   vidx;
    logic          err;
  } job_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_DIV, FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE, BE_BW, BE_MAC, BE_DONE
  } be_state_t;
endpackage

>>> rtl/bicubic_bezier_patch_eval.sv
// Bicubic Bezier patch evaluator top level.
// Evaluate item: restoring division and a queue hand-off in the front end, then weight,
// multiply-accumulate and finishing steps in the engine; a range error skips the weight and
// multiply-accumulate steps. The front end can divide the next item while the engine is busy.
// A load item gives no result and is stalled while an evaluation is in flight.
// Reset (rst_n low, synchronous) sets div_u and div_v to 1 and clears all points.
module bicubic_bezier_patch_eval import bbpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  logic jf_valid, jf_stall, jq_valid, jq_stall;
  job_t jf, jq;
  logic [3:0] rd_addr;
  logic [3*COORD_BITS-1:0] rd_data;

  bbpe_front u_front (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .in_data, .back_busy(jq_valid || jq_stall), .job_valid(jf_valid), .job_stall(jf_stall),
    .job(jf), .rd_addr, .rd_data);
  bbpe_queue u_queue (.clk, .rst_n, .wr_valid(jf_valid), .wr_stall(jf_stall), .wr_data(jf),
    .rd_valid(jq_valid), .rd_stall(jq_stall), .rd_data(jq));
  bbpe_engine u_engine (.clk, .rst_n, .job_valid(jq_valid), .job_stall(jq_stall), .job(jq),
    .rd_addr, .rd_data, .out_valid, .out_stall, .out_data);

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |-> out_data.pos_x == '0 && out_data.vertex_index == '0)
    else $error("error result with nonzero payload");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode |=> in_stall)
    else $error("front end took an item while dividing");
endmodule

>>> rtl/bbpe_front.sv
// Front end: takes items, stores control points, forms u and v by restoring division.
module bbpe_front import bbpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  logic      back_busy,
  output logic      job_valid,
  input  logic      job_stall,
  output job_t      job,
  input  logic [3:0] rd_addr,
  output logic [3*COORD_BITS-1:0] rd_data
);
  localparam int NB = FRAC_BITS + 8;

  logic [7:0] div_u_r, div_v_r;
  logic [3*COORD_BITS-1:0] pts_r [16];
  logic [15:0] pv_r;
  fe_state_t st_r, st_nxt;
  logic [NB-1:0] qu_r, qv_r, qu_nxt, qv_nxt;
  logic [8:0] ru_r, rv_r, ru_nxt, rv_nxt;
  logic [4:0] cnt_r;
  logic [7:0] du_r, dv_r;
  logic [15:0] vidx_r;
  logic err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_u_r <= 8'd1;
      div_v_r <= 8'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DIV_U) div_u_r <= cfg_data;
      if (cfg_index == CFG_DIV_V) div_v_r <= cfg_data;
    end
  end

  logic take;
  // A load waits until no evaluation that still reads the point store is left behind it.
  assign in_stall = (st_r != FE_IDLE) || (!in_data.mode && back_busy);
  assign take = in_valid && !in_stall;

  // Valid bits stand in for clearing the point store at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= '0;
    else if (take && !in_data.mode) pv_r[in_data.point_index] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (take && !in_data.mode)
      pts_r[in_data.point_index] <= {in_data.point_x, in_data.point_y, in_data.point_z};
  end
  assign rd_data = pv_r[rd_addr] ? pts_r[rd_addr] : '0;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FE_IDLE: if (take && in_data.mode) st_nxt = FE_DIV;
      FE_DIV:  if (cnt_r == 5'd0) st_nxt = FE_PUSH;
      FE_PUSH: if (!job_stall) st_nxt = FE_IDLE;
      default: st_nxt = FE_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= FE_IDLE;
    else st_r <= st_nxt;
  end

  // One quotient bit per cycle for both directions.
  always_comb begin
    logic [9:0] tu, tv;
    logic bu, bv;
    bu = (qu_r[NB-1]);
    bv = (qv_r[NB-1]);
    tu = {ru_r, bu} - {2'b0, du_r};
    tv = {rv_r, bv} - {2'b0, dv_r};
    qu_nxt = {qu_r[NB-2:0], !tu[9]};
    qv_nxt = {qv_r[NB-2:0], !tv[9]};
    ru_nxt = tu[9] ? {ru_r[7:0], bu} : tu[8:0];
    rv_nxt = tv[9] ? {rv_r[7:0], bv} : tv[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (take && in_data.mode) cnt_r <= 5'(NB - 1);
    else if (st_r == FE_DIV) cnt_r <= cnt_r - 5'd1;
  end

  always_ff @(posedge clk) begin
    logic [7:0] du, dv;
    du = (div_u_r == 8'd0) ? 8'd1 : div_u_r;
    dv = (div_v_r == 8'd0) ? 8'd1 : div_v_r;
    if (take && in_data.mode) begin
      du_r <= du;
      dv_r <= dv;
      qu_r <= {in_data.grid_col, FRAC_BITS'(0)};
      qv_r <= {in_data.grid_row, FRAC_BITS'(0)};
      ru_r <= '0;
      rv_r <= '0;
      err_r <= (in_data.grid_col > du) || (in_data.grid_row > dv);
      vidx_r <= 16'(in_data.grid_col) + (16'(du) + 16'd1) * 16'(in_data.grid_row);
    end else if (st_r == FE_DIV) begin
      qu_r <= qu_nxt;
      qv_r <= qv_nxt;
      ru_r <= ru_nxt;
      rv_r <= rv_nxt;
    end
  end

  assign job_valid = (st_r == FE_PUSH);
  assign job = {err_r ? TW'(0) : qu_r[TW-1:0], err_r ? TW'(0) : qv_r[TW-1:0],
                err_r ? 16'd0 : vidx_r, err_r};
endmodule

>>> rtl/bbpe_queue.sv
// Two-entry job queue between front end and evaluation engine.
module bbpe_queue import bbpe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output job_t rd_data
);
  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) if (wr) mem_r[wp_r] <= wr_data;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

>>> rtl/bbpe_engine.sv
// Evaluation engine: Bernstein weights, then one multiply-accumulate per point per cycle.
module bbpe_engine import bbpe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_stall,
  input  job_t job,
  output logic [3:0] rd_addr,
  input  logic [3*COORD_BITS-1:0] rd_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data
);
  localparam int AW = COORD_BITS + FRAC_BITS + 6;
  localparam int PW = COORD_BITS + TW;

  be_state_t st_r, st_nxt;
  logic [3:0] bstep_r, idx_r;
  logic [TW-1:0] tu_r, tv_r, wu_r, wv_r, mul_a, mul_b;
  logic [TW-1:0] t2_r, w2_r;
  logic [TW-1:0] bu_r [4];
  logic [TW-1:0] bv_r [4];
  logic [15:0] vidx_r;
  logic err_r;
  logic signed [AW-1:0] acc_r [3];
  logic [TW-1:0] wgt_r;
  logic [3*COORD_BITS-1:0] pt_r;
  logic mv_r;
  logic emit;
  logic ovalid_r;
  out_item_t odata_r;

  assign job_stall = (st_r != BE_IDLE);
  // The last product lands in the cycle after the final point, so the result waits for it.
  assign emit = (st_r == BE_DONE) && !mv_r && (!ovalid_r || !out_stall);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BE_IDLE: if (job_valid) st_nxt = job.err ? BE_DONE : BE_BW;
      BE_BW:   if (bstep_r == 4'd11) st_nxt = BE_MAC;
      BE_MAC:  if (idx_r == 4'd15) st_nxt = BE_DONE;
      BE_DONE: if (emit) st_nxt = BE_IDLE;
      default: st_nxt = BE_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BE_IDLE;
    else st_r <= st_nxt;
  end

  // One narrow product per cycle builds the eight weights.
  logic [2*TW+1:0] prod;
  logic [TW-1:0] ps;
  assign prod = mul_a * mul_b;
  assign ps = prod[FRAC_BITS +: TW];
  always_comb begin
    mul_a = tu_r; mul_b = tu_r;
    case (bstep_r)
      4'd0:  begin mul_a = tu_r; mul_b = tu_r; end
      4'd1:  begin mul_a = wu_r; mul_b = wu_r; end
      4'd2:  begin mul_a = w2_r; mul_b = wu_r; end
      4'd3:  begin mul_a = tu_r; mul_b = w2_r; end
      4'd4:  begin mul_a = t2_r; mul_b = wu_r; end
      4'd5:  begin mul_a = t2_r; mul_b = tu_r; end
      4'd6:  begin mul_a = tv_r; mul_b = tv_r; end
      4'd7:  begin mul_a = wv_r; mul_b = wv_r; end
      4'd8:  begin mul_a = w2_r; mul_b = wv_r; end
      4'd9:  begin mul_a = tv_r; mul_b = w2_r; end
      4'd10: begin mul_a = t2_r; mul_b = wv_r; end
      4'd11: begin mul_a = t2_r; mul_b = tv_r; end
      default: begin mul_a = tu_r; mul_b = tu_r; end
    endcase
  end
  logic [2*TW+3:0] p3;
  logic [TW-1:0] p3s;
  assign p3 = {2'b0, prod} * (2*TW+4)'(3);
  assign p3s = p3[FRAC_BITS +: TW];

  always_ff @(posedge clk) begin
    if (st_r == BE_IDLE && job_valid) begin
      tu_r <= job.tu; tv_r <= job.tv;
      wu_r <= TW'(1 << FRAC_BITS) - job.tu;
      wv_r <= TW'(1 << FRAC_BITS) - job.tv;
      vidx_r <= job.vidx; err_r <= job.err;
      bstep_r <= '0;
    end else if (st_r == BE_BW) begin
      bstep_r <= bstep_r + 4'd1;
      case (bstep_r)
        4'd0, 4'd6:  t2_r <= ps;
        4'd1, 4'd7:  w2_r <= ps;
        4'd2:  bu_r[0] <= ps;
        4'd3:  bu_r[1] <= p3s;
        4'd4:  bu_r[2] <= p3s;
        4'd5:  bu_r[3] <= ps;
        4'd8:  bv_r[0] <= ps;
        4'd9:  bv_r[1] <= p3s;
        4'd10: bv_r[2] <= p3s;
        4'd11: bv_r[3] <= ps;
        default: ;
      endcase
    end
  end

  // Weight for the current point, registered ahead of the coordinate products.
  logic [2*TW-1:0] wp;
  logic [TW-1:0] wgt;
  assign wp = bu_r[idx_r[1:0]] * bv_r[idx_r[3:2]];
  assign wgt = wp[FRAC_BITS +: TW];
  assign rd_addr = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else mv_r <= (st_r == BE_MAC);
  end
  always_ff @(posedge clk) begin
    if (st_r == BE_MAC) begin
      wgt_r <= wgt;
      pt_r <= rd_data;
    end
  end

  // Floor of p*w/2^F equals the arithmetic shift of the full product.
  function automatic logic signed [AW-1:0] term(input logic signed [COORD_BITS-1:0] p,
                                                input logic [TW-1:0] w);
    logic signed [PW:0] full;
    full = p * $signed({1'b0, w});
    return AW'(full >>> FRAC_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (st_r == BE_BW && bstep_r == 4'd11) begin
      idx_r <= '0;
      for (int c = 0; c < 3; c++) acc_r[c] <= '0;
    end else begin
      if (st_r == BE_MAC) idx_r <= idx_r + 4'd1;
      if (mv_r) begin
        acc_r[0] <= acc_r[0] + term(pt_r[3*COORD_BITS-1 -: COORD_BITS], wgt_r);
        acc_r[1] <= acc_r[1] + term(pt_r[2*COORD_BITS-1 -: COORD_BITS], wgt_r);
        acc_r[2] <= acc_r[2] + term(pt_r[COORD_BITS-1:0], wgt_r);
      end
    end
  end

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [AW-1:0] s);
    logic signed [AW-1:0] mx, mn;
    mx = AW'({1'b0, {(COORD_BITS-1){1'b1}}});
    mn = -mx - AW'(1);
    if (s > mx) return mx[COORD_BITS-1:0];
    if (s < mn) return mn[COORD_BITS-1:0];
    return s[COORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (emit) ovalid_r <= 1'b1;
    else if (!out_stall) ovalid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (emit) begin
      odata_r.pos_x <= err_r ? '0 : sat(acc_r[0]);
      odata_r.pos_y <= err_r ? '0 : sat(acc_r[1]);
      odata_r.pos_z <= err_r ? '0 : sat(acc_r[2]);
      odata_r.vertex_index <= vidx_r;
      odata_r.range_error <= err_r;
    end
  end
  assign out_valid = ovalid_r;
  assign out_data = odata_r;
endmodule
